### rtl/bbe_pkg.sv
// Shared constants and types for the B-spline basis evaluator.
// Used by bbe_term_unit, bbe_engine and bspline_basis_eval; no dependencies.
package bbe_pkg;

   localparam int KNOT_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int BASIS_W    = FRAC_W + 1;
   localparam int IDX_W      = 6;
   localparam int CNT_W      = 7;
   localparam int DEG_W      = 4;
   localparam int PROD_W     = KNOT_W + BASIS_W;
   localparam int MAX_DEGREE = 9;
   localparam int OUT_LIMIT  = 62;

   localparam logic [BASIS_W-1:0] BASIS_ONE = BASIS_W'(1) << FRAC_W;

   // Item kinds
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   // Register indexes
   localparam logic CSR_DEGREE      = 1'b0;
   localparam logic CSR_BASIS_COUNT = 1'b1;

   // Request to the shared weight-times-basis unit
   typedef struct packed {
      logic                start;
      logic [KNOT_W-1:0]   lo;
      logic [KNOT_W-1:0]   hi;
      logic [KNOT_W-1:0]   num;
      logic [BASIS_W-1:0]  prev;
   } term_req_type;

   // One result item
   typedef struct packed {
      logic [IDX_W-1:0]    index;
      logic [BASIS_W-1:0]  value;
      logic                status;
      logic                last;
   } result_type;

endpackage

### rtl/bbe_term_unit.sv
// Shared term unit: floor(min(num,hi-lo) * prev / (hi-lo)), zero when hi <= lo or prev is zero.
// A multiply state then a restoring divider, one quotient bit per cycle. Uses bbe_pkg.
module bbe_term_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  bbe_pkg::term_req_type      req,
   output logic                       done,
   output logic [bbe_pkg::BASIS_W-1:0] result
);

   typedef enum logic [3:0] {
      T_IDLE = 4'b0001,
      T_MUL  = 4'b0010,
      T_DIV  = 4'b0100,
      T_DONE = 4'b1000
   } tstate_type;

   localparam int STEP_W = $clog2(bbe_pkg::BASIS_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(bbe_pkg::BASIS_W - 1);

   tstate_type                      state_ff, state_in;
   logic [bbe_pkg::KNOT_W-1:0]      den_ff, den_in;
   logic [bbe_pkg::KNOT_W-1:0]      num_ff, num_in;
   logic [bbe_pkg::BASIS_W-1:0]     prev_ff, prev_in;
   logic [bbe_pkg::KNOT_W-1:0]      rem_ff, rem_in;
   logic [bbe_pkg::BASIS_W-1:0]     lq_ff, lq_in;
   logic [STEP_W-1:0]               step_ff, step_in;
   logic [bbe_pkg::KNOT_W-1:0]      diff;
   logic [bbe_pkg::PROD_W-1:0]      prod;
   logic [bbe_pkg::KNOT_W:0]        rem2;
   logic                            ge;

   assign done   = (state_ff == T_DONE);
   assign result = lq_ff;

   // Next-state logic for multiply and divide
   always_comb begin
      state_in = state_ff;
      den_in   = den_ff;
      num_in   = num_ff;
      prev_in  = prev_ff;
      rem_in   = rem_ff;
      lq_in    = lq_ff;
      step_in  = step_ff;
      diff     = req.hi - req.lo;
      prod     = bbe_pkg::PROD_W'(num_ff) * bbe_pkg::PROD_W'(prev_ff);
      rem2     = {rem_ff, lq_ff[bbe_pkg::BASIS_W-1]};
      ge       = (rem2 >= {1'b0, den_ff});
      unique case (state_ff)
         T_IDLE: begin
            if (req.start) begin
               if ((req.hi <= req.lo) || (req.prev == '0)) begin
                  lq_in    = '0;
                  state_in = T_DONE;
               end else begin
                  den_in   = diff;
                  num_in   = (req.num > diff) ? diff : req.num;
                  prev_in  = req.prev;
                  state_in = T_MUL;
               end
            end
         end
         T_MUL: begin
            rem_in   = prod[bbe_pkg::PROD_W-1:bbe_pkg::BASIS_W];
            lq_in    = prod[bbe_pkg::BASIS_W-1:0];
            step_in  = '0;
            state_in = T_DIV;
         end
         T_DIV: begin
            rem_in  = ge ? bbe_pkg::KNOT_W'(rem2 - {1'b0, den_ff})
                         : rem2[bbe_pkg::KNOT_W-1:0];
            lq_in   = {lq_ff[bbe_pkg::BASIS_W-2:0], ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = T_DONE;
            end
         end
         T_DONE: begin
            state_in = T_IDLE;
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // Hold state; only control is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
      end else begin
         state_ff <= state_in;
      end
      den_ff  <= den_in;
      num_ff  <= num_in;
      prev_ff <= prev_in;
      rem_ff  <= rem_in;
      lq_ff   <= lq_in;
      step_ff <= step_in;
   end

endmodule

### rtl/bbe_engine.sv
// Sequencer around the knot memory and the basis working memory: span search,
// Cox-de Boor levels and result readout. Uses bbe_pkg and bbe_term_unit.
module bbe_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         op,
   input  logic [bbe_pkg::IDX_W-1:0]    knot_index,
   input  logic [bbe_pkg::KNOT_W-1:0]   knot_value,
   input  logic [bbe_pkg::KNOT_W-1:0]   param_t,
   input  logic [bbe_pkg::DEG_W-1:0]    degree_cfg,
   input  logic [bbe_pkg::IDX_W-1:0]    count_cfg,
   output logic                         res_valid,
   output bbe_pkg::result_type          res,
   input  logic                         res_ready
);

   typedef enum logic [17:0] {
      E_IDLE   = 18'b000000000000000001,
      E_FIRST  = 18'b000000000000000010,
      E_FINAL  = 18'b000000000000000100,
      E_CHECK  = 18'b000000000000001000,
      E_SCAN_A = 18'b000000000000010000,
      E_SCAN_D = 18'b000000000000100000,
      E_INIT   = 18'b000000000001000000,
      E_K0     = 18'b000000000010000000,
      E_K1     = 18'b000000000100000000,
      E_K2     = 18'b000000001000000000,
      E_K3     = 18'b000000010000000000,
      E_K4     = 18'b000000100000000000,
      E_K5     = 18'b000001000000000000,
      E_F_WAIT = 18'b000010000000000000,
      E_G_GO   = 18'b000100000000000000,
      E_G_WAIT = 18'b001000000000000000,
      E_OUT_A  = 18'b010000000000000000,
      E_OUT_B  = 18'b100000000000000000
   } estate_type;

   localparam int DEPTH = 1 << bbe_pkg::IDX_W;
   localparam int KW = bbe_pkg::KNOT_W;
   localparam int BW = bbe_pkg::BASIS_W;
   localparam int CW = bbe_pkg::CNT_W;

   // Memories
   logic [KW-1:0] kmem [DEPTH];
   logic [BW-1:0] bmem [DEPTH];
   logic [KW-1:0] kdata_ff;
   logic [BW-1:0] bdata_ff;
   logic [bbe_pkg::IDX_W-1:0] kaddr, baddr;
   logic          kwe, bwe;
   logic [BW-1:0] bwdata;

   estate_type    state_ff, state_in;
   logic [KW-1:0] t_ff, t_in, first_ff, first_in, final_ff, final_in;
   logic [KW-1:0] u0_ff, u0_in, up_ff, up_in, u1_ff, u1_in, up1_ff, up1_in;
   logic [BW-1:0] b0_ff, b0_in, b1_ff, b1_in, s0_ff, s0_in;
   logic [bbe_pkg::DEG_W-1:0] d_ff, d_in, p_ff, p_in;
   logic [bbe_pkg::IDX_W-1:0] n_ff, n_in, span_ff, span_in;
   logic [CW-1:0] knots_ff, knots_in, i_ff, i_in;
   logic          bad_ff, bad_in, found_ff, found_in;

   logic [bbe_pkg::DEG_W-1:0] d_clamp;
   logic [bbe_pkg::IDX_W-1:0] n_max, n_clamp;
   logic [CW-1:0] lvl_lim, scan_lim, i_p, i_p1, i_1;
   logic [BW:0]   sum;

   bbe_pkg::term_req_type treq;
   logic          tdone;
   logic [BW-1:0] tres;

   bbe_term_unit u_term (
      .clock  (clock),
      .reset  (reset),
      .req    (treq),
      .done   (tdone),
      .result (tres)
   );

   // Clamp the configuration
   always_comb begin
      if (degree_cfg < bbe_pkg::DEG_W'(1)) begin
         d_clamp = bbe_pkg::DEG_W'(1);
      end else if (degree_cfg > bbe_pkg::DEG_W'(bbe_pkg::MAX_DEGREE)) begin
         d_clamp = bbe_pkg::DEG_W'(bbe_pkg::MAX_DEGREE);
      end else begin
         d_clamp = degree_cfg;
      end
      n_max = bbe_pkg::IDX_W'(DEPTH - 1) - bbe_pkg::IDX_W'(d_clamp);
      if (n_max > bbe_pkg::IDX_W'(bbe_pkg::OUT_LIMIT)) begin
         n_max = bbe_pkg::IDX_W'(bbe_pkg::OUT_LIMIT);
      end
      if (count_cfg < bbe_pkg::IDX_W'(2)) begin
         n_clamp = bbe_pkg::IDX_W'(2);
      end else if (count_cfg > n_max) begin
         n_clamp = n_max;
      end else begin
         n_clamp = count_cfg;
      end
   end

   assign scan_lim = knots_ff - CW'(2);
   assign lvl_lim  = knots_ff - CW'(2) - CW'(p_ff);
   assign i_1      = i_ff + CW'(1);
   assign i_p      = i_ff + CW'(p_ff);
   assign i_p1     = i_p + CW'(1);
   assign sum      = {1'b0, s0_ff} + {1'b0, tres};
   assign req_ready = (state_ff == E_IDLE);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      t_in = t_ff; first_in = first_ff; final_in = final_ff;
      u0_in = u0_ff; up_in = up_ff; u1_in = u1_ff; up1_in = up1_ff;
      b0_in = b0_ff; b1_in = b1_ff; s0_in = s0_ff;
      d_in = d_ff; p_in = p_ff; n_in = n_ff; span_in = span_ff;
      knots_in = knots_ff; i_in = i_ff; bad_in = bad_ff; found_in = found_ff;
      kaddr  = i_ff[bbe_pkg::IDX_W-1:0];
      baddr  = i_ff[bbe_pkg::IDX_W-1:0];
      kwe    = 1'b0;
      bwe    = 1'b0;
      bwdata = '0;
      treq   = '0;
      res_valid = 1'b0;
      res.index  = i_ff[bbe_pkg::IDX_W-1:0];
      res.value  = bad_ff ? '0 : bdata_ff;
      res.status = bad_ff;
      res.last   = (i_ff == CW'(n_ff) - CW'(1));
      unique case (state_ff)
         E_IDLE: begin
            kaddr = knot_index;
            if (req_valid) begin
               if (op == bbe_pkg::OP_WRITE) begin
                  kwe = 1'b1;
               end else begin
                  t_in     = param_t;
                  d_in     = d_clamp;
                  n_in     = n_clamp;
                  knots_in = CW'(n_clamp) + CW'(d_clamp) + CW'(1);
                  found_in = 1'b0;
                  span_in  = '0;
                  state_in = E_FIRST;
               end
            end
         end
         E_FIRST: begin
            kaddr    = '0;
            state_in = E_FINAL;
         end
         E_FINAL: begin
            kaddr    = bbe_pkg::IDX_W'(knots_ff - CW'(1));
            first_in = kdata_ff;
            state_in = E_CHECK;
         end
         E_CHECK: begin
            final_in = kdata_ff;
            bad_in   = (t_ff < first_ff) || (t_ff > kdata_ff);
            i_in     = '0;
            state_in = ((t_ff < first_ff) || (t_ff > kdata_ff)) ? E_OUT_A : E_SCAN_A;
         end
         E_SCAN_A: begin
            state_in = E_SCAN_D;
         end
         E_SCAN_D: begin
            if ((kdata_ff <= t_ff) && (kdata_ff < final_ff)) begin
               span_in  = i_ff[bbe_pkg::IDX_W-1:0];
               found_in = 1'b1;
            end
            if (i_ff == scan_lim) begin
               i_in     = '0;
               state_in = E_INIT;
            end else begin
               i_in     = i_1;
               state_in = E_SCAN_A;
            end
         end
         E_INIT: begin
            // Seed level zero with one at the span
            bwe    = 1'b1;
            bwdata = (found_ff && (i_ff[bbe_pkg::IDX_W-1:0] == span_ff)) ? bbe_pkg::BASIS_ONE
                                                                         : '0;
            if (i_ff == scan_lim) begin
               i_in     = '0;
               p_in     = bbe_pkg::DEG_W'(1);
               state_in = E_K0;
            end else begin
               i_in = i_1;
            end
         end
         E_K0: begin
            state_in = E_K1;
         end
         E_K1: begin
            u0_in    = kdata_ff;
            kaddr    = i_p[bbe_pkg::IDX_W-1:0];
            state_in = E_K2;
         end
         E_K2: begin
            up_in    = kdata_ff;
            kaddr    = i_1[bbe_pkg::IDX_W-1:0];
            state_in = E_K3;
         end
         E_K3: begin
            u1_in    = kdata_ff;
            kaddr    = i_p1[bbe_pkg::IDX_W-1:0];
            state_in = E_K4;
         end
         E_K4: begin
            up1_in   = kdata_ff;
            b0_in    = bdata_ff;
            baddr    = i_1[bbe_pkg::IDX_W-1:0];
            state_in = E_K5;
         end
         E_K5: begin
            // Start the rising term
            b1_in      = bdata_ff;
            treq.start = 1'b1;
            treq.lo    = u0_ff;
            treq.hi    = up_ff;
            treq.num   = (t_ff > u0_ff) ? t_ff - u0_ff : '0;
            treq.prev  = b0_ff;
            state_in   = E_F_WAIT;
         end
         E_F_WAIT: begin
            if (tdone) begin
               s0_in    = tres;
               state_in = E_G_GO;
            end
         end
         E_G_GO: begin
            // Start the falling term
            treq.start = 1'b1;
            treq.lo    = u1_ff;
            treq.hi    = up1_ff;
            treq.num   = (up1_ff > t_ff) ? up1_ff - t_ff : '0;
            treq.prev  = b1_ff;
            state_in   = E_G_WAIT;
         end
         E_G_WAIT: begin
            if (tdone) begin
               bwe    = 1'b1;
               bwdata = (sum > {1'b0, bbe_pkg::BASIS_ONE}) ? bbe_pkg::BASIS_ONE
                                                           : sum[BW-1:0];
               if (i_ff == lvl_lim) begin
                  i_in = '0;
                  if (p_ff == d_ff) begin
                     state_in = E_OUT_A;
                  end else begin
                     p_in     = p_ff + bbe_pkg::DEG_W'(1);
                     state_in = E_K0;
                  end
               end else begin
                  i_in     = i_1;
                  state_in = E_K0;
               end
            end
         end
         E_OUT_A: begin
            state_in = E_OUT_B;
         end
         E_OUT_B: begin
            res_valid = 1'b1;
            if (res_ready) begin
               if (res.last) begin
                  state_in = E_IDLE;
               end else begin
                  i_in     = i_1;
                  state_in = E_OUT_A;
               end
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   // Knot memory and basis memory, registered read
   always_ff @(posedge clock) begin
      if (kwe) begin
         kmem[kaddr] <= knot_value;
      end
      kdata_ff <= kmem[kaddr];
      if (bwe) begin
         bmem[baddr] <= bwdata;
      end
      bdata_ff <= bmem[baddr];
   end

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
      t_ff <= t_in; first_ff <= first_in; final_ff <= final_in;
      u0_ff <= u0_in; up_ff <= up_in; u1_ff <= u1_in; up1_ff <= up1_in;
      b0_ff <= b0_in; b1_ff <= b1_in; s0_ff <= s0_in;
      d_ff <= d_in; p_ff <= p_in; n_ff <= n_in; span_ff <= span_in;
      knots_ff <= knots_in; i_ff <= i_in; bad_ff <= bad_in; found_ff <= found_in;
   end

endmodule

### rtl/bspline_basis_eval.sv
// B-spline basis evaluator, top level: channels, configuration registers, output register.
// Uses bbe_pkg and bbe_engine.
//
// Usage:
//   req channel: tuser = op (0 writes knot, 1 evaluates). A write stores one knot and
//   gives no result. An evaluate item gives basis_count result
//   items on rsp, index 0 first, tlast on the final one, tuser = status (1 when
//   t lies outside the knot range, all values then zero).
//   csr port: index 0 degree (1..9), index 1 basis_count (2..62, at most 63 - degree);
//   write only while no evaluation is running.
// Sequence: an evaluation first runs span search and seeding over the K knots,
// then for each term pair four knot reads, two basis reads and two passes of
// the shared term unit, each a multiply state, 17 divide steps and a done
// state (a zero term goes straight to done), over all terms of the d levels,
// then readout of each result through states E_OUT_A and E_OUT_B. One
// evaluation is in flight at a time; req_tready is high only when the
// sequencer is idle.
// Reset clears control state and sets degree 3, basis_count 4; knots are
// undefined until written. A stall on rsp holds the output register and pauses
// readout; the next item is accepted while the final result still waits.
module bspline_basis_eval (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // knot_index[5:0], knot_value[37:6], param_t[69:38], zero
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // basis_index[5:0], basis_value[22:6], zero
   output logic        rsp_tuser,   // status
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [5:0]  csr_wdata
);

   logic [bbe_pkg::DEG_W-1:0] degree_ff;
   logic [bbe_pkg::IDX_W-1:0] count_ff;
   logic                      res_valid, res_ready;
   bbe_pkg::result_type       res;
   logic                      out_valid_ff;
   bbe_pkg::result_type       out_ff;

   bbe_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .op         (req_tuser),
      .knot_index (req_tdata[5:0]),
      .knot_value (req_tdata[37:6]),
      .param_t    (req_tdata[69:38]),
      .degree_cfg (degree_ff),
      .count_cfg  (count_ff),
      .res_valid  (res_valid),
      .res        (res),
      .res_ready  (res_ready)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= bbe_pkg::DEG_W'(3);
         count_ff  <= bbe_pkg::IDX_W'(4);
      end else if (csr_we) begin
         unique case (csr_addr)
            bbe_pkg::CSR_DEGREE:      degree_ff <= csr_wdata[bbe_pkg::DEG_W-1:0];
            bbe_pkg::CSR_BASIS_COUNT: count_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Output register: load when empty or being drained
   assign res_ready = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res_ready) begin
         out_valid_ff <= res_valid;
      end
      if (res_ready && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.value, out_ff.index};
   assign rsp_tuser  = out_ff.status;
   assign rsp_tlast  = out_ff.last;

`ifndef SYNTHESIS
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[22:6] == '0)
      else $error("out-of-range item carries a nonzero value");

   a_value_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:6] <= bbe_pkg::BASIS_ONE)
      else $error("basis value above one");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("evaluate item did not occupy the sequencer");
`endif

endmodule

### test/testbench.sv
// Self-checking testbench for bspline_basis_eval: knot writes, basis evaluations, csr settings.
// Depends on bbe_pkg and the RTL top level; all stimulus and prediction live in this file.
module testbench;

   localparam int LIMIT = 20000000;

   typedef struct {
      logic        op;
      logic [5:0]  index;
      logic [31:0] value;
      logic [31:0] t;
   } knot_req_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic        csr_addr;
   logic [5:0]  csr_wdata;

   // predictor state
   logic [31:0]  knot_mem [64];
   logic [16:0]  basis_mem [64];
   logic [3:0]   cfg_degree;
   logic [5:0]   cfg_count;

   knot_req_type         pending [$];
   knot_req_type         cur_item;
   bbe_pkg::result_type  basis_expect [$];
   bit           burst_mode;
   int           gap_left;
   int           stall_left;
   int           stall_draw;
   int           fail_count;
   int           n_items;
   int           n_evals;
   int           n_results;
   int           n_outside;
   longint       cycles;
   logic [31:0]  plan [64];

   bspline_basis_eval i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // weight times previous level value, zero for an empty knot interval
   function automatic logic [63:0] weighted(logic [31:0] lo, logic [31:0] hi,
                                            logic [63:0] num, logic [16:0] prev);
      logic [63:0] den;
      if (hi <= lo || prev == 0) return 0;
      den = hi - lo;
      if (num > den) num = den;
      return (num * prev) / den;
   endfunction

   // apply one accepted item to the knot store, or queue the basis values it yields
   function automatic void predict_basis(knot_req_type it);
      int          d, n, nmax, k, span, i, p;
      bit          bad, found;
      logic [31:0] first, fin;
      logic [63:0] fnum, gnum, s;
      bbe_pkg::result_type r;
      if (it.op == bbe_pkg::OP_WRITE) begin
         knot_mem[it.index] = it.value;
         return;
      end
      d = cfg_degree;
      if (d < 1) d = 1;
      if (d > bbe_pkg::MAX_DEGREE) d = bbe_pkg::MAX_DEGREE;
      nmax = 64 - d - 1;
      if (nmax > bbe_pkg::OUT_LIMIT) nmax = bbe_pkg::OUT_LIMIT;
      n = cfg_count;
      if (n < 2) n = 2;
      if (n > nmax) n = nmax;
      k = n + d + 1;
      first = knot_mem[0];
      fin = knot_mem[k-1];
      bad = (it.t < first) || (it.t > fin);
      found = 0;
      span = 0;
      if (!bad) begin
         for (i = 0; i + 1 < k; i++)
            if (knot_mem[i] <= it.t && knot_mem[i] < fin) begin
               span = i;
               found = 1;
            end
         for (i = 0; i + 1 < k; i++)
            basis_mem[i] = (found && i == span) ? bbe_pkg::BASIS_ONE : '0;
         for (p = 1; p <= d; p++)
            for (i = 0; i + 1 + p < k; i++) begin
               fnum = (it.t > knot_mem[i]) ? it.t - knot_mem[i] : 0;
               gnum = (knot_mem[i+p+1] > it.t) ? knot_mem[i+p+1] - it.t : 0;
               s = weighted(knot_mem[i], knot_mem[i+p], fnum, basis_mem[i]) +
                   weighted(knot_mem[i+1], knot_mem[i+p+1], gnum, basis_mem[i+1]);
               basis_mem[i] = (s > bbe_pkg::BASIS_ONE) ? bbe_pkg::BASIS_ONE : s[16:0];
            end
      end
      for (i = 0; i < n; i++) begin
         r.index = 6'(i);
         r.value = bad ? '0 : basis_mem[i];
         r.status = bad;
         r.last = (i + 1 == n);
         basis_expect.insert(basis_expect.size(), r);
      end
      n_evals++;
   endfunction

   // driver: present queued items, random gap between them outside burst mode
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            predict_basis(cur_item);
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending.size() > 0) begin
            cur_item = pending.pop_front();
            req_tdata <= {2'b00, cur_item.t, cur_item.value, cur_item.index};
            req_tuser <= cur_item.op;
            req_tvalid <= 1'b1;
            gap_left <= burst_mode ? 0 : $urandom_range(10, 0);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: random stalls outside burst mode, compare each result with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tready) begin
         if (rsp_tvalid) begin
            if (basis_expect.size() == 0) begin
               $error("unexpected result: index %0d value %0d", rsp_tdata[5:0],
                      rsp_tdata[22:6]);
               fail_count++;
            end else begin
               bbe_pkg::result_type e;
               e = basis_expect.pop_front();
               if (rsp_tdata[5:0] !== e.index) begin
                  $error("basis_index: expected %0d, got %0d", e.index, rsp_tdata[5:0]);
                  fail_count++;
               end
               if (rsp_tdata[22:6] !== e.value) begin
                  $error("basis_value: expected %0d, got %0d", e.value, rsp_tdata[22:6]);
                  fail_count++;
               end
               if (rsp_tuser !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last: expected %0d, got %0d", e.last, rsp_tlast);
                  fail_count++;
               end
               if (e.status) n_outside++;
            end
            n_results++;
            stall_draw = burst_mode ? 0 : $urandom_range(10, 0);
            stall_left <= stall_draw;
            rsp_tready <= (stall_draw == 0);
         end
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic push_item(logic op, logic [5:0] idx, logic [31:0] v, logic [31:0] t);
      knot_req_type it;
      it.op = op;
      it.index = idx;
      it.value = v;
      it.t = t;
      pending.insert(pending.size(), it);
      n_items++;
   endtask

   task automatic put_knot(int idx, logic [31:0] v);
      plan[idx] = v;
      push_item(bbe_pkg::OP_WRITE, 6'(idx), v, $urandom);
   endtask

   task automatic put_eval(logic [31:0] t);
      push_item(bbe_pkg::OP_EVAL, 6'($urandom), $urandom, t);
   endtask

   // hold until every item is taken and every result has come, then let the block settle
   task automatic drain;
      while (pending.size() > 0 || req_tvalid || basis_expect.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic addr, logic [5:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= v;
      if (addr == bbe_pkg::CSR_DEGREE) cfg_degree = v[3:0];
      else cfg_count = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // fill knots 0..k-1 in one of several shapes
   task automatic put_knots(int k, int d, int shape);
      longint acc;
      int     i, j;
      logic [31:0] tmp;
      acc = (shape == 4) ? 0 : $urandom_range(32'h0080_0000, 0);
      for (i = 0; i < k; i++) begin
         if (shape == 2) plan[i] = 32'h0003_0000;
         else begin
            if (shape == 4) acc += $urandom_range(32'h1000_0000, 0);
            else if (!(shape == 1 && (i <= d || i >= k - d - 1)))
               acc += ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(32'h0004_0000, 1);
            plan[i] = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
         end
      end
      // knots out of order: swap a pair
      if (shape == 3) begin
         i = $urandom_range(k - 1, 0);
         j = $urandom_range(k - 1, 0);
         tmp = plan[i];
         plan[i] = plan[j];
         plan[j] = tmp;
      end
      for (i = 0; i < k; i++) put_knot(i, plan[i]);
   endtask

   // pick t: mostly inside the knot range, sometimes on a knot or outside it
   function automatic logic [31:0] pick_t(int k);
      logic [31:0] lo, hi;
      int          sel;
      lo = plan[0];
      hi = plan[k-1];
      sel = $urandom_range(9, 0);
      if (sel == 0 && lo > 0) return $urandom_range(lo - 1, 0);
      if (sel == 1 && hi < 32'hFFFF_FFFF) return $urandom_range(32'hFFFF_FFFF, hi + 1);
      if (sel == 2) return plan[$urandom_range(k - 1, 0)];
      if (hi < lo) return $urandom;
      return $urandom_range(hi, lo);
   endfunction

   task automatic eval_phase(int deg, int cnt, int shape, int evals);
      int d, n, k, i;
      d = (deg < 1) ? 1 : (deg > bbe_pkg::MAX_DEGREE) ? bbe_pkg::MAX_DEGREE : deg;
      n = (cnt < 2) ? 2 : (cnt > 63 - d) ? 63 - d : cnt;
      if (n > bbe_pkg::OUT_LIMIT) n = bbe_pkg::OUT_LIMIT;
      k = n + d + 1;
      write_csr(bbe_pkg::CSR_DEGREE, 6'(deg));
      write_csr(bbe_pkg::CSR_BASIS_COUNT, 6'(cnt));
      burst_mode = ($urandom_range(4, 0) == 0);
      put_knots(k, d, shape);
      for (i = 0; i < evals; i++) put_eval(pick_t(k));
      drain();
   endtask

   initial begin
      int deg, cnt, i;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = bbe_pkg::OP_WRITE;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = bbe_pkg::CSR_DEGREE;
      csr_wdata = '0;
      cycles = 0;
      fail_count = 0;
      n_items = 0;
      n_evals = 0;
      n_results = 0;
      n_outside = 0;
      burst_mode = 0;
      cfg_degree = 3;
      cfg_count = 4;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // every knot defined once, full value range, reset settings
      for (i = 0; i < 64; i++)
         put_knot(i, (i < 8) ? 32'h0001_0000 * (i + 1) : 32'hFFFF_FFFF - (63 - i));
      put_eval(32'h0001_0000);
      put_eval(32'h0008_0000);
      put_eval(32'h0000_8000);
      put_eval(32'h0008_0001);
      put_eval(32'h0004_8000);
      put_eval(32'h0002_0000);
      drain();

      // every knot equal: no span
      write_csr(bbe_pkg::CSR_DEGREE, 6'd2);
      write_csr(bbe_pkg::CSR_BASIS_COUNT, 6'd3);
      for (i = 0; i < 6; i++) put_knot(i, 32'h0005_0000);
      put_eval(32'h0005_0000);
      // top of the range, t at the largest value
      put_knot(5, 32'hFFFF_FFFF);
      put_eval(32'hFFFF_FFFF);
      // knots out of order
      put_knot(2, 32'h0006_0000);
      put_knot(3, 32'h0001_0000);
      put_eval(32'h0005_8000);
      drain();

      // extreme and saturated settings
      eval_phase(0, 0, 0, 2);
      eval_phase(15, 63, 1, 2);
      eval_phase(1, 62, 4, 3);
      eval_phase(9, 2, 0, 2);

      // random phases, mostly small sizes
      while (n_items < 450) begin
         if ($urandom_range(11, 0) == 0) begin
            deg = $urandom_range(2, 1);
            cnt = $urandom_range(62, 20);
         end else begin
            deg = $urandom_range(4, 1);
            cnt = $urandom_range(8, 2);
         end
         eval_phase(deg, cnt, ($urandom_range(5, 0) < 3) ? $urandom_range(1, 0)
                                                          : $urandom_range(4, 2),
                    $urandom_range(8, 3));
      end

      drain();
      $display("Covered %0d items, %0d evaluations, %0d basis values (%0d out of range).",
               n_items, n_evals, n_results, n_outside);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
